[hdl/int4_block_quantizer_defines.svh]
// ---------------------------------------------------------------------------
// int4_block_quantizer assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef INT4_BLOCK_QUANTIZER_DEFINES_SVH
`define INT4_BLOCK_QUANTIZER_DEFINES_SVH

// Checked only outside reset.
`define I4BQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define I4BQ_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/i4bq_pkg.sv]
// ---------------------------------------------------------------------------
// i4bq_pkg
// Types and constants shared by the blockwise int4 quantizer.
// ---------------------------------------------------------------------------
package i4bq_pkg;

  localparam int BLOCK_SIZE = 32;
  localparam int IDX_W      = (BLOCK_SIZE > 2) ? $clog2(BLOCK_SIZE) : 1;
  localparam int NBYTES     = (BLOCK_SIZE + 1) / 2;
  localparam int BIDX_W     = (NBYTES > 1) ? $clog2(NBYTES) : 1;

  localparam int SAMPLE_W   = 16;
  localparam int RANGE_W    = 16;
  localparam int SCALE_W    = 28;
  localparam int CODE_W     = 4;
  localparam int BYTE_W     = 8;
  localparam int OUT_DATA_W = 40;

  // Scale divider: (2*15*256*65536 + range) / (2*range).
  localparam int NUM_W      = 29;
  localparam int DEN_W      = RANGE_W + 1;
  localparam int DCNT_W     = $clog2(NUM_W);
  localparam logic [NUM_W-1:0]   SCALE_NUM2 = NUM_W'(2 * 251658240);
  localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(65536);

  // Rounding thresholds: odd multiples of the divisor, 1 to 15.
  localparam int NLEVELS    = 8;
  localparam int TH_W       = 20;
  localparam logic [RANGE_W-1:0] ZERO_RANGE_DEN = RANGE_W'(256);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_DIV,
    ST_HDR,
    ST_RD_HI,
    ST_RD_LO,
    ST_EMIT
  } i4bq_state_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [IDX_W-1:0]    addr;
    logic [SAMPLE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hdl/i4bq_sample_ram.sv]
// ---------------------------------------------------------------------------
// i4bq_sample_ram
// Single-port sample store with a registered read.
// ---------------------------------------------------------------------------
`include "int4_block_quantizer_defines.svh"

module i4bq_sample_ram (
  input  logic                               clk,
  input  logic                               rst,
  input  i4bq_pkg::ram_req_t                 req,
  output logic [i4bq_pkg::SAMPLE_W-1:0]      rd_data
);
  import i4bq_pkg::*;

  logic [SAMPLE_W-1:0] mem [BLOCK_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Read data holds until the next read, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

  // Loading and draining are separate phases, so a write never meets a read.
  `I4BQ_ASSERT(a_no_rw_overlap, !(req.we && req.re), "sample store read and write in one cycle")

endmodule

[hdl/i4bq_scale_div.sv]
// ---------------------------------------------------------------------------
// i4bq_scale_div
// Restoring divider, one quotient bit per cycle, for the block scale.
// ---------------------------------------------------------------------------
module i4bq_scale_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [i4bq_pkg::NUM_W-1:0]        num,
  input  logic [i4bq_pkg::DEN_W-1:0]        den,
  output i4bq_pkg::div_status_t             status,
  output logic [i4bq_pkg::SCALE_W-1:0]      quot
);
  import i4bq_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DEN_W:0]    trial;
  logic [DEN_W+1:0]  diff;
  logic              qbit;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_r};
    qbit  = !diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(NUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], qbit};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot        = quo[SCALE_W-1:0];

endmodule

[hdl/i4bq_coder.sv]
// ---------------------------------------------------------------------------
// i4bq_coder
// Turns one sample into a saturated 4-bit code against per-block thresholds.
// ---------------------------------------------------------------------------
module i4bq_coder (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic                                 zero_range,
  input  logic [i4bq_pkg::RANGE_W-1:0]         range,
  input  logic signed [i4bq_pkg::SAMPLE_W-1:0] sample,
  output logic [i4bq_pkg::CODE_W-1:0]          code
);
  import i4bq_pkg::*;

  logic [TH_W-1:0]     thr [NLEVELS];
  logic                unit_mul;
  logic [RANGE_W-1:0]  den;
  logic                neg;
  logic [SAMPLE_W:0]   mag_wide;
  logic [SAMPLE_W-1:0] mag;
  logic [TH_W-1:0]     val;
  logic [CODE_W-1:0]   q;

  assign den = zero_range ? ZERO_RANGE_DEN : range;

  // Threshold k is (2k+1)*den; the magnitude code is the count of
  // thresholds that twice the scaled magnitude reaches.
  always_ff @(posedge clk) begin
    if (load) begin
      unit_mul <= zero_range;
      for (int k = 0; k < NLEVELS; k++) begin
        thr[k] <= TH_W'(den) * TH_W'(2 * k + 1);
      end
    end
  end

  always_comb begin
    neg      = sample[SAMPLE_W-1];
    mag_wide = neg ? -{sample[SAMPLE_W-1], sample} : {1'b0, sample};
    mag      = mag_wide[SAMPLE_W-1:0];
    if (unit_mul) begin
      val = TH_W'(mag) << 1;
    end else begin
      val = ((TH_W'(mag) << 4) - TH_W'(mag)) << 1;
    end
    q = '0;
    for (int k = 0; k < NLEVELS; k++) begin
      q = q + CODE_W'(val >= thr[k]);
    end
    // A negative magnitude of eight wraps to the code for -8 by itself.
    if (neg) begin
      code = -q;
    end else if (q[CODE_W-1]) begin
      code = CODE_W'(7);
    end else begin
      code = q;
    end
  end

endmodule

[hdl/int4_block_quantizer.sv]
// ---------------------------------------------------------------------------
// int4_block_quantizer
// Blockwise symmetric int4 quantizer with a Q12.16 scale header per block.
// ---------------------------------------------------------------------------
// Samples arrive on the s_axis channel, one signed Q8.8 value per beat, and
// are written to the sample store at one beat per cycle while loading, as the
// running minimum and maximum are tracked. After the last sample of a block
// the input stalls: the start state registers the range and starts the
// restoring divider on the scale, then the header beat goes out on m_axis
// (tuser high) followed by the packed payload bytes, tlast on the final one.
// Each byte needs two store reads, for its high and low nibble, and then an
// emit state, so the sequencer starts no new byte until the last is loaded.
// A stalled receiver holds the output register; the sequencer waits and the
// input stays not ready until the final byte is in the output register.
// Reset clears the sequencer, the fill count and the min/max trackers;
// the sample store is not cleared, since every entry is written before use.
// ---------------------------------------------------------------------------
`include "int4_block_quantizer_defines.svh"

module int4_block_quantizer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [i4bq_pkg::SAMPLE_W-1:0]         s_axis_tdata,   // [15:0] sample
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [i4bq_pkg::OUT_DATA_W-1:0]       m_axis_tdata,   // [27:0] scale_q16,
                                                                // [35:28] packed_byte
  output logic                                  m_axis_tuser,   // [0] is_header
  output logic                                  m_axis_tlast
);
  import i4bq_pkg::*;

  i4bq_state_t state, state_next;

  logic [IDX_W-1:0]           fill;
  logic [BIDX_W-1:0]          byte_idx;
  logic signed [SAMPLE_W-1:0] rmin;
  logic signed [SAMPLE_W-1:0] rmax;
  logic                       zero_range;
  logic [CODE_W-1:0]          hi_nib;

  logic                       out_valid;
  logic                       out_is_header;
  logic [SCALE_W-1:0]         out_scale;
  logic [BYTE_W-1:0]          out_byte;
  logic                       out_last;

  logic                       in_beat;
  logic                       out_free;
  logic [SAMPLE_W:0]          diff_wide;
  logic [RANGE_W-1:0]         range_val;
  logic                       range_zero;
  logic                       has_lo;
  logic                       last_byte;
  logic [IDX_W-1:0]           hi_addr;
  logic [IDX_W-1:0]           lo_addr;

  ram_req_t                   ram_req;
  logic [SAMPLE_W-1:0]        rd_data;
  logic                       div_start;
  div_status_t                div_st;
  logic [SCALE_W-1:0]         div_quot;
  logic                       coder_load;
  logic [CODE_W-1:0]          code;
  logic                       hdr_load;
  logic                       byte_load;
  logic                       hi_capture;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid || m_axis_tready;
  assign diff_wide  = {rmax[SAMPLE_W-1], rmax} - {rmin[SAMPLE_W-1], rmin};
  assign range_val  = diff_wide[RANGE_W-1:0];
  assign range_zero = (range_val == '0);
  assign has_lo     = (32'(byte_idx) * 2 + 1) < BLOCK_SIZE;
  assign last_byte  = (byte_idx == BIDX_W'(NBYTES - 1));
  assign hi_addr    = IDX_W'({byte_idx, 1'b0});
  assign lo_addr    = IDX_W'({byte_idx, 1'b1});

  i4bq_sample_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  i4bq_scale_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (SCALE_NUM2 + NUM_W'(range_val)),
    .den    ({range_val, 1'b0}),
    .status (div_st),
    .quot   (div_quot)
  );

  i4bq_coder u_coder (
    .clk        (clk),
    .load       (coder_load),
    .zero_range (range_zero),
    .range      (range_val),
    .sample     (rd_data),
    .code       (code)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_beat && fill == IDX_W'(BLOCK_SIZE - 1)) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_st.done) begin
          state_next = ST_HDR;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          state_next = ST_RD_HI;
        end
      end
      ST_RD_HI: state_next = ST_RD_LO;
      ST_RD_LO: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = last_byte ? ST_LOAD : ST_RD_HI;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = fill;
    ram_req.wdata = s_axis_tdata;
    div_start     = 1'b0;
    coder_load    = 1'b0;
    hdr_load      = 1'b0;
    byte_load     = 1'b0;
    hi_capture    = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        ram_req.we    = in_beat;
      end
      ST_START: begin
        div_start  = 1'b1;
        coder_load = 1'b1;
      end
      ST_DIV: ;
      ST_HDR: hdr_load = out_free;
      ST_RD_HI: begin
        ram_req.re   = 1'b1;
        ram_req.addr = hi_addr;
      end
      ST_RD_LO: begin
        hi_capture   = 1'b1;
        ram_req.re   = has_lo;
        ram_req.addr = lo_addr;
      end
      ST_EMIT: byte_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      fill      <= '0;
      byte_idx  <= '0;
      rmin      <= SAMPLE_MAX;
      rmax      <= SAMPLE_MIN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_beat) begin
        fill <= (fill == IDX_W'(BLOCK_SIZE - 1)) ? '0 : fill + 1'b1;
        if ($signed(s_axis_tdata) < rmin) begin
          rmin <= $signed(s_axis_tdata);
        end
        if ($signed(s_axis_tdata) > rmax) begin
          rmax <= $signed(s_axis_tdata);
        end
      end
      if (state == ST_START) begin
        rmin <= SAMPLE_MAX;
        rmax <= SAMPLE_MIN;
      end
      if (hdr_load) begin
        out_valid <= 1'b1;
        byte_idx  <= '0;
      end else if (byte_load) begin
        out_valid <= 1'b1;
        byte_idx  <= last_byte ? '0 : byte_idx + 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_START) begin
      zero_range <= range_zero;
    end
    if (hi_capture) begin
      hi_nib <= code;
    end
    if (hdr_load) begin
      out_is_header <= 1'b1;
      out_scale     <= zero_range ? SCALE_ONE : div_quot;
      out_byte      <= '0;
      out_last      <= 1'b0;
    end else if (byte_load) begin
      out_is_header <= 1'b0;
      out_scale     <= '0;
      out_byte      <= {hi_nib, has_lo ? code : CODE_W'(0)};
      out_last      <= last_byte;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - SCALE_W - BYTE_W)'(0), out_byte, out_scale};
  assign m_axis_tuser  = out_is_header;
  assign m_axis_tlast  = out_last;

  `I4BQ_ASSERT_NORST(a_rst_clears_out, rst |=> !m_axis_tvalid, "output valid after reset")
  `I4BQ_ASSERT(a_hdr_after_div, (state == ST_HDR) |-> !div_st.busy, "header while divider busy")
  `I4BQ_ASSERT(a_hdr_not_last, (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tlast, "header beat marked last")
  `I4BQ_ASSERT(a_byte_loads_out, (state == ST_EMIT && out_free) |=> m_axis_tvalid, "payload byte not presented")

endmodule
